// ===== src/ldf_pkg.sv =====
// Shared types, constants and helper functions of the display decimal field formatter.
// Depends on nothing; every other file of the block refers to it by scoped names.
package ldf_pkg;

    // Input request: cursor position, number to print and the number of digits.
    typedef struct packed {
        logic [7:0]  row;
        logic [7:0]  column;
        logic [15:0] value;
        logic [7:0]  digit_count;
    } t_item;

    // One display byte: a cursor command or a character.
    typedef struct packed {
        logic       is_command;
        logic [7:0] out_byte;
        logic       last;
    } t_result;

    // What follows the cursor command of a request.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_DIGITS,
        KIND_ERROR
    } t_kind;

    // Classified request as it waits between the front and the back end.
    typedef struct packed {
        logic [7:0]  cursor;
        t_kind       kind;
        logic [2:0]  ndig;
        logic [15:0] value;
    } t_job;

    // Sequencer states of the back end.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_ERROR
    } t_state;

    localparam logic [7:0] CMD_ROW1_BASE = 8'h7F;
    localparam logic [7:0] CMD_ROW2_BASE = 8'hBF;
    localparam logic [7:0] CMD_HOME      = 8'h80;
    localparam logic [7:0] ASCII_ZERO    = 8'd48;
    localparam logic [7:0] ERR_CHAR      = 8'h65;
    localparam logic [7:0] NUM_COLUMNS   = 8'd16;
    localparam logic [7:0] MAX_DIGITS    = 8'd5;
    localparam logic [2:0] TOP_POS       = 3'd4;

    localparam int JOB_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 2;

    // Power of ten for a digit position, units at position zero.
    function automatic logic [13:0] pow10(input logic [2:0] pos);
        logic [13:0] p;
        case (pos)
            3'd0: p = 14'd1;
            3'd1: p = 14'd10;
            3'd2: p = 14'd100;
            3'd3: p = 14'd1000;
            3'd4: p = 14'd10000;
            default: p = 14'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== src/ldf_fifo.sv =====
// Small register queue with full and empty flags, used for requests and for results.
// Depends on ldf_pkg for its default depth and width.
module ldf_fifo #(
    parameter int DEPTH = ldf_pkg::RES_DEPTH_DEF,
    parameter int WIDTH = $bits(ldf_pkg::t_result)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    // Flags and the oldest entry.
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    // Storage; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== src/ldf_front.sv =====
// Front end: accepts requests, works out the cursor command and the kind of field,
// and queues the classified request. Depends on ldf_pkg and ldf_fifo.
module ldf_front #(
    parameter int DEPTH = ldf_pkg::JOB_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ldf_pkg::t_item      i_item,
    output logic                o_full,
    output logic                o_job_valid,
    output ldf_pkg::t_job       o_job,
    input  logic                i_job_take
);
    logic                row_ok;
    logic                col_ok;
    ldf_pkg::t_job       job;
    logic                job_empty;
    logic [$bits(ldf_pkg::t_job)-1:0] job_bits;

    // Cursor command; an invalid position falls back to row 1, column 1.
    assign row_ok = (i_item.row == 8'd1) || (i_item.row == 8'd2);
    assign col_ok = (i_item.column != 8'd0) && (i_item.column <= ldf_pkg::NUM_COLUMNS);

    always_comb begin
        if (!(row_ok && col_ok)) begin
            job.cursor = ldf_pkg::CMD_HOME;
        end else if (i_item.row == 8'd1) begin
            job.cursor = ldf_pkg::CMD_ROW1_BASE + i_item.column;
        end else begin
            job.cursor = ldf_pkg::CMD_ROW2_BASE + i_item.column;
        end

        // Field kind: nothing, digits, or the error mark.
        if (i_item.digit_count == 8'd0) begin
            job.kind = ldf_pkg::KIND_NONE;
        end else if (i_item.digit_count > ldf_pkg::MAX_DIGITS) begin
            job.kind = ldf_pkg::KIND_ERROR;
        end else begin
            job.kind = ldf_pkg::KIND_DIGITS;
        end
        job.ndig  = i_item.digit_count[2:0];
        job.value = i_item.value;
    end

    // Queue toward the back end.
    ldf_fifo #(
        .DEPTH (DEPTH),
        .WIDTH ($bits(ldf_pkg::t_job))
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_wdata (job),
        .o_full  (o_full),
        .o_empty (job_empty),
        .i_rd    (i_job_take),
        .o_rdata (job_bits)
    );

    assign o_job_valid = !job_empty;
    assign o_job       = ldf_pkg::t_job'(job_bits);

endmodule

// ===== src/ldf_back.sv =====
// Back end (depends on ldf_pkg): sequences a classified request's display bytes, one
// step a cycle unless results are full; a digit unit peels one decimal digit per step.
module ldf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  ldf_pkg::t_job      i_job,
    output logic               o_job_take,
    input  logic               i_res_full,
    output logic               o_res_push,
    output ldf_pkg::t_result   o_res
);
    ldf_pkg::t_state r_state;
    ldf_pkg::t_state n_state;
    logic [15:0]     r_rem;
    logic [15:0]     n_rem;
    logic [2:0]      r_pos;
    logic [2:0]      n_pos;
    logic [2:0]      r_ndig;
    logic [2:0]      n_ndig;

    logic [13:0]     weight;
    logic [16:0]     thr [10];
    logic [3:0]      digit;
    logic [16:0]     rem_diff;

    // Digit unit: compare the remainder against every multiple of the weight.
    assign weight = ldf_pkg::pow10(r_pos);

    always_comb begin
        for (int k = 0; k < 10; k++) begin
            thr[k] = 17'(k) * {3'b000, weight};
        end
        digit = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if ({1'b0, r_rem} >= thr[k]) begin
                digit = 4'(k);
            end
        end
        rem_diff = {1'b0, r_rem} - thr[digit];
    end

    // State and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ldf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_pos  <= n_pos;
        r_ndig <= n_ndig;
    end

    // Next state and outputs; nothing moves while the result queue is full.
    always_comb begin
        n_state    = r_state;
        n_rem      = r_rem;
        n_pos      = r_pos;
        n_ndig     = r_ndig;
        o_job_take = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        case (r_state)
            ldf_pkg::ST_IDLE: begin
                if (i_job_valid && !i_res_full) begin
                    o_job_take       = 1'b1;
                    o_res_push       = 1'b1;
                    o_res.is_command = 1'b1;
                    o_res.out_byte   = i_job.cursor;
                    o_res.last       = (i_job.kind == ldf_pkg::KIND_NONE);
                    n_rem            = i_job.value;
                    n_pos            = ldf_pkg::TOP_POS;
                    n_ndig           = i_job.ndig;
                    case (i_job.kind)
                        ldf_pkg::KIND_DIGITS: n_state = ldf_pkg::ST_DIGIT;
                        ldf_pkg::KIND_ERROR:  n_state = ldf_pkg::ST_ERROR;
                        default:              n_state = ldf_pkg::ST_IDLE;
                    endcase
                end
            end
            ldf_pkg::ST_DIGIT: begin
                // High positions beyond the requested count are worked but not sent.
                if (!i_res_full) begin
                    o_res_push       = (r_pos < r_ndig);
                    o_res.is_command = 1'b0;
                    o_res.out_byte   = ldf_pkg::ASCII_ZERO + {4'b0000, digit};
                    o_res.last       = (r_pos == 3'd0);
                    n_rem            = rem_diff[15:0];
                    if (r_pos == 3'd0) begin
                        n_state = ldf_pkg::ST_IDLE;
                    end else begin
                        n_pos = r_pos - 3'd1;
                    end
                end
            end
            ldf_pkg::ST_ERROR: begin
                if (!i_res_full) begin
                    o_res_push       = 1'b1;
                    o_res.is_command = 1'b0;
                    o_res.out_byte   = ldf_pkg::ERR_CHAR;
                    o_res.last       = 1'b1;
                    n_state          = ldf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ldf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lcd_decimal_field_formatter.sv =====
// Top level of the display decimal field formatter: front end, back end, result queue.
// Depends on ldf_pkg, ldf_fifo, ldf_front and ldf_back.
//
//   Channel  | Direction | Handshake        | Payload
//   ---------+-----------+------------------+-------------------------------------
//   request  | in        | push / full      | i_item  (row, column, value, digits)
//   result   | out       | empty / pop      | o_result (is_command, out_byte, last)
//
// A request with digits takes a cursor step and five digit steps of the shared digit
// unit, one with no digits only that step, one with the error mark that step and an
// error step. The back end sets the sustained rate; the request queue lets the front
// accept while the back end works. Reset is synchronous and clears all queue and
// sequencer control. A full result queue stalls the back end without losing bytes.
module lcd_decimal_field_formatter #(
    parameter int JOB_DEPTH = ldf_pkg::JOB_DEPTH_DEF,
    parameter int RES_DEPTH = ldf_pkg::RES_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  ldf_pkg::t_item     i_item,
    output logic               empty,
    input  logic               pop,
    output ldf_pkg::t_result   o_result
);
    logic                               job_valid;
    ldf_pkg::t_job                      job;
    logic                               job_take;
    logic                               res_full;
    logic                               res_push;
    ldf_pkg::t_result                   res;
    logic [$bits(ldf_pkg::t_result)-1:0] res_bits;

    // Request intake and classification.
    ldf_front #(
        .DEPTH (JOB_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_take  (job_take)
    );

    // Byte sequencing.
    ldf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_take  (job_take),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // Result queue toward the display driver.
    ldf_fifo #(
        .DEPTH (RES_DEPTH),
        .WIDTH ($bits(ldf_pkg::t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res),
        .o_full  (res_full),
        .o_empty (empty),
        .i_rd    (pop),
        .o_rdata (res_bits)
    );

    assign o_result = ldf_pkg::t_result'(res_bits);

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the display decimal field formatter: directed and random requests under idling.
// Depends on ldf_pkg and lcd_decimal_field_formatter; checks every display byte in arrival order.
module tb;

    localparam int HALF_PERIOD      = 4;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int HOLD_LEN         = 300;
    localparam int TAIL_CYCLES      = 20;
    localparam int RANDOM_PER_PHASE = 55;
    localparam int PRESSURE_ITEMS   = 24;
    localparam int TOP_DIVISOR      = 10000;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push    = 1'b0;
    logic             pop     = 1'b0;
    ldf_pkg::t_item   i_item  = '0;
    logic             full;
    logic             empty;
    ldf_pkg::t_result o_result;

    // Requests waiting to be offered and display bytes waiting to arrive.
    ldf_pkg::t_item   pending_requests[$];
    ldf_pkg::t_result expected_bytes[$];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_arm       = 1'b0;
    int   hold_left      = 0;
    int   error_count    = 0;
    int   cycle_count    = 0;

    lcd_decimal_field_formatter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic ldf_pkg::t_result make_byte(input logic cmd, input logic [7:0] code);
        ldf_pkg::t_result r;
        r.is_command = cmd;
        r.out_byte   = code;
        r.last       = 1'b0;
        return r;
    endfunction

    // Work out the display bytes of one request: cursor command, then digits or the error mark.
    task automatic format_field(input ldf_pkg::t_item req);
        ldf_pkg::t_result seq [6];
        logic [7:0]       cursor;
        int               n;
        int               pos;
        int               divisor;
        int               digit;
        int               k;
        if (req.row < 8'd1 || req.row > 8'd2 || req.column < 8'd1 ||
            req.column > ldf_pkg::NUM_COLUMNS)
            cursor = ldf_pkg::CMD_HOME;
        else if (req.row == 8'd1)
            cursor = ldf_pkg::CMD_ROW1_BASE + req.column;
        else
            cursor = ldf_pkg::CMD_ROW2_BASE + req.column;
        seq[0] = make_byte(1'b1, cursor);
        n = 1;
        if (req.digit_count > ldf_pkg::MAX_DIGITS) begin
            seq[n] = make_byte(1'b0, ldf_pkg::ERR_CHAR);
            n = n + 1;
        end else begin
            for (pos = int'(req.digit_count); pos >= 1; pos = pos - 1) begin
                // The top digit of a five-digit field is not reduced modulo ten.
                if (pos == 5) begin
                    digit = int'(req.value) / TOP_DIVISOR;
                end else begin
                    divisor = 1;
                    repeat (pos - 1) divisor = divisor * 10;
                    digit = (int'(req.value) / divisor) % 10;
                end
                seq[n] = make_byte(1'b0, ldf_pkg::ASCII_ZERO + digit[7:0]);
                n = n + 1;
            end
        end
        seq[n - 1].last = 1'b1;
        for (k = 0; k < n; k = k + 1)
            expected_bytes.push_back(seq[k]);
    endtask

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count = error_count + 1;
    endtask

    task automatic add_request(input logic [7:0] row, input logic [7:0] column,
                               input logic [15:0] value, input logic [7:0] digit_count);
        ldf_pkg::t_item req;
        req.row         = row;
        req.column      = column;
        req.value       = value;
        req.digit_count = digit_count;
        pending_requests.push_back(req);
    endtask

    // Mostly valid positions and counts, with a share of arbitrary bytes in row, column and digit count.
    function automatic ldf_pkg::t_item random_request();
        ldf_pkg::t_item req;
        if ($urandom_range(0, 9) < 8)
            req.row = 8'($urandom_range(1, 2));
        else
            req.row = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 8)
            req.column = 8'($urandom_range(1, 16));
        else
            req.column = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            req.value = 16'(32'hFFFF - $urandom_range(0, 5535));
        else
            req.value = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 9) < 8)
            req.digit_count = 8'($urandom_range(0, 5));
        else
            req.digit_count = 8'($urandom_range(0, 255));
        return req;
    endfunction

    // Wait until every request has been taken and every byte has come back.
    task automatic drain_all();
        while (pending_requests.size() != 0 || expected_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int count, input int send_pct, input int recv_pct);
        int i;
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (i = 0; i < count; i = i + 1)
            pending_requests.push_back(random_request());
        drain_all();
    endtask

    // Driver: offers the oldest pending request and decides on pop at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            pop  <= 1'b0;
        end else begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                push   <= 1'b1;
                i_item <= pending_requests[0];
            end else begin
                push <= 1'b0;
            end
            pop <= !(hold_arm || hold_left != 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted down here once armed.
    always @(posedge i_clk) begin
        if (hold_arm)
            hold_left <= HOLD_LEN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: predicts accepted requests and checks accepted bytes against the oldest expectation.
    always @(posedge i_clk) begin : monitor
        ldf_pkg::t_result want;
        if (i_rst_n) begin
            if (push && !full) begin
                format_field(i_item);
                void'(pending_requests.pop_front());
            end
            if (pop && !empty) begin
                if (expected_bytes.size() == 0) begin
                    report_error($sformatf("unexpected byte cmd=%0b byte=%02h last=%0b",
                                           o_result.is_command, o_result.out_byte,
                                           o_result.last));
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_result.is_command !== want.is_command ||
                        o_result.out_byte !== want.out_byte ||
                        o_result.last !== want.last)
                        report_error($sformatf(
                            "got cmd=%0b byte=%02h last=%0b, want cmd=%0b byte=%02h last=%0b",
                            o_result.is_command, o_result.out_byte, o_result.last,
                            want.is_command, want.out_byte, want.last));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: position fallbacks, field extremes and every digit count class.
        @(posedge i_clk);
        add_request(8'd1,   8'd1,   16'd0,     8'd0);
        add_request(8'd2,   8'd16,  16'd65535, 8'd5);
        add_request(8'd1,   8'd16,  16'd12345, 8'd5);
        add_request(8'd2,   8'd1,   16'd9,     8'd1);
        add_request(8'd0,   8'd5,   16'd54321, 8'd2);
        add_request(8'd3,   8'd5,   16'd100,   8'd3);
        add_request(8'd255, 8'd255, 16'd65535, 8'd255);
        add_request(8'd1,   8'd0,   16'd4242,  8'd4);
        add_request(8'd2,   8'd17,  16'd59999, 8'd5);
        add_request(8'd2,   8'd255, 16'd7,     8'd6);
        add_request(8'd1,   8'd8,   16'd60000, 8'd5);
        add_request(8'd2,   8'd9,   16'd1,     8'd4);
        add_request(8'd1,   8'd2,   16'd65535, 8'd4);
        add_request(8'd2,   8'd3,   16'd0,     8'd5);
        add_request(8'd128, 8'd1,   16'd32768, 8'd128);
        add_request(8'd1,   8'd128, 16'd21845, 8'd3);
        add_request(8'd2,   8'd12,  16'd43690, 8'd7);
        add_request(8'd2,   8'd16,  16'd0,     8'd0);
        add_request(8'd1,   8'd15,  16'd10000, 8'd5);
        drain_all();

        // Random phases with different idling on each side.
        run_phase(RANDOM_PER_PHASE, 0, 0);
        run_phase(RANDOM_PER_PHASE, 64, 0);
        run_phase(RANDOM_PER_PHASE, 0, 64);
        run_phase(RANDOM_PER_PHASE, 37, 37);

        // Backpressure: the receiver holds off while requests keep coming, so input stalls.
        @(posedge i_clk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (PRESSURE_ITEMS) pending_requests.push_back(random_request());
        @(negedge i_clk);
        hold_arm <= 1'b1;
        @(negedge i_clk);
        hold_arm <= 1'b0;
        drain_all();

        run_phase(RANDOM_PER_PHASE / 2, 37, 37);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_bytes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
